// ----- design/chip8_instruction_execute_defines.svh -----
// Assertion macros used by the checker file c8x_checker.
// Both expect a clock named clk in scope; C8X_CHECK also expects an active-low reset named rst_n.
`ifndef CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH

// Check outside of reset.
`define C8X_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define C8X_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/c8x_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_pkg
// Types, codes and field helpers of the CHIP-8 execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int unsigned MEM_DEPTH_DEF = 4096;

  localparam logic [15:0] X_MASK   = 16'h0F00;
  localparam logic [15:0] Y_MASK   = 16'h00F0;
  localparam logic [15:0] KK_MASK  = 16'h00FF;
  localparam logic [15:0] NNN_MASK = 16'h0FFF;
  localparam logic [7:0]  MSB_MASK = 8'b1000_0000;
  localparam logic [7:0]  BYTE_MAX = 8'hFF;
  localparam logic [3:0]  VF_ADDR  = 4'hF;

  typedef enum logic [4:0] {
    OP_JP      = 5'd0,
    OP_SE_KK   = 5'd1,
    OP_SE_XY   = 5'd2,
    OP_SNE_KK  = 5'd3,
    OP_SNE_XY  = 5'd4,
    OP_LD_KK   = 5'd5,
    OP_LD_XY   = 5'd6,
    OP_LD_I    = 5'd7,
    OP_LD_X_DT = 5'd8,
    OP_LD_DT_X = 5'd9,
    OP_LD_ST_X = 5'd10,
    OP_STORE   = 5'd11,
    OP_LOAD    = 5'd12,
    OP_ADD_KK  = 5'd13,
    OP_ADD_XY  = 5'd14,
    OP_ADD_I   = 5'd15,
    OP_SUB     = 5'd16,
    OP_SUBN    = 5'd17,
    OP_OR      = 5'd18,
    OP_AND     = 5'd19,
    OP_XOR     = 5'd20,
    OP_SHR     = 5'd21,
    OP_SHL     = 5'd22
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WBX,
    ST_MOD,
    ST_STORE,
    ST_LOAD,
    ST_OUTRD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [7:0] data;
  } vreg_wr_t;

  function automatic logic [3:0] field_x(input logic [15:0] word);
    logic [15:0] t;
    t = (word & X_MASK) >> 8;
    return t[3:0];
  endfunction

  function automatic logic [3:0] field_y(input logic [15:0] word);
    logic [15:0] t;
    t = (word & Y_MASK) >> 4;
    return t[3:0];
  endfunction

  function automatic logic [7:0] field_kk(input logic [15:0] word);
    logic [15:0] t;
    t = word & KK_MASK;
    return t[7:0];
  endfunction

  function automatic logic [11:0] field_nnn(input logic [15:0] word);
    logic [15:0] t;
    t = word & NNN_MASK;
    return t[11:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/c8x_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_if
// Valid/ready channels of the execute unit: instruction in, machine state out.
// ----------------------------------------------------------------------------
interface c8x_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  mode;
  logic [15:0] instruction_word;

  modport source (output valid, output mode, output instruction_word, input ready);
  modport sink   (input valid, input mode, input instruction_word, output ready);
endinterface

interface c8x_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [15:0] index_value;
  logic [7:0]  delay_value;
  logic [7:0]  sound_value;
  logic [7:0]  vx_value;
  logic [7:0]  flag_value;

  modport source (output valid, output program_counter, output index_value,
                  output delay_value, output sound_value, output vx_value,
                  output flag_value, input ready);
  modport sink   (input valid, input program_counter, input index_value,
                  input delay_value, input sound_value, input vx_value,
                  input flag_value, output ready);
endinterface
`default_nettype wire

// ----- design/c8x_vregs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_vregs
// V register file: 16 x 8, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module c8x_vregs (
  input  wire logic             clk,
  input  wire c8x_pkg::vreg_wr_t wr,
  input  wire logic [3:0]       rd_a_addr,
  input  wire logic [3:0]       rd_b_addr,
  output logic      [7:0]       rd_a_data,
  output logic      [7:0]       rd_b_data
);

  logic [7:0] vreg_mem_r [16];
  logic [7:0] rd_a_data_r;
  logic [7:0] rd_b_data_r;

  // read returns the old value when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      vreg_mem_r[wr.addr] <= wr.data;
    end
    rd_a_data_r <= vreg_mem_r[rd_a_addr];
    rd_b_data_r <= vreg_mem_r[rd_b_addr];
  end

  assign rd_a_data = rd_a_data_r;
  assign rd_b_data = rd_b_data_r;

endmodule
`default_nettype wire

// ----- design/c8x_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_mem
// Main byte memory: single port, registered read.
// ----------------------------------------------------------------------------
module c8x_mem #(
  parameter int unsigned MEM_DEPTH = c8x_pkg::MEM_DEPTH_DEF,
  localparam int unsigned AW = $clog2(MEM_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem_r [MEM_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- design/c8x_addr_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_addr_mod
// Reduction of the 16-bit index modulo the memory depth: reciprocal multiply
// for the quotient, multiply back and subtract, then one conditional subtract.
// The result is valid while done is high.
// ----------------------------------------------------------------------------
module c8x_addr_mod #(
  parameter int unsigned MEM_DEPTH = c8x_pkg::MEM_DEPTH_DEF,
  localparam int unsigned AW = $clog2(MEM_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [15:0]   value,
  output logic               done,
  output logic      [AW-1:0] result
);

  // floor(2^24 / depth) leaves the quotient estimate at most one short
  localparam logic [16:0] DEPTH = 17'(MEM_DEPTH);
  localparam logic [16:0] RECIP = 17'((32'd1 << 24) / MEM_DEPTH);

  logic        stage1_r;
  logic        stage2_r;
  logic        done_r;
  logic [15:0] value_r;
  logic [7:0]  quot_r;
  logic [15:0] rem_r;
  logic [31:0] prod;
  logic [31:0] quot_depth;
  logic [16:0] rem_ext;
  logic [16:0] rem_fix;

  assign prod       = {16'b0, value_r} * {15'b0, RECIP};
  assign quot_depth = {24'b0, quot_r} * {15'b0, DEPTH};
  assign rem_ext    = {1'b0, rem_r};
  assign rem_fix    = (rem_ext >= DEPTH) ? (rem_ext - DEPTH) : rem_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage1_r <= 1'b0;
      stage2_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      stage1_r <= start;
      stage2_r <= stage1_r;
      done_r   <= stage2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      value_r <= value;
    end
    if (stage1_r) begin
      quot_r <= prod[31:24];
    end
    if (stage2_r) begin
      rem_r <= value_r - quot_depth[15:0];
    end
  end

  assign done   = done_r;
  assign result = rem_fix[AW-1:0];

endmodule
`default_nettype wire

// ----- design/chip8_instruction_execute.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// CHIP-8 execute unit: one instruction per input transfer, one state report
// per instruction.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its byte memory to zero, one entry a cycle, and
// clears the V registers on the way; in_ch.ready stays low until the sweep
// ends. Each accepted instruction then runs through a sequencer around the V
// register file and the main memory, both with registered reads. Register and
// arithmetic operations pass through a Vx write-back state when they write Vx,
// while block store and load first reduce I to a memory address and then use
// the single memory port that moves one register per cycle. A finished report
// sits in an output register, so the next instruction is taken while it waits.
module chip8_instruction_execute #(
  parameter int unsigned MEM_DEPTH = c8x_pkg::MEM_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  c8x_in_if.sink     in_ch,
  c8x_out_if.source  out_ch
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

  c8x_pkg::state_t state_r, state_nxt;

  logic [4:0]    mode_r;
  logic [15:0]   word_r;
  logic [3:0]    x_r;
  logic [11:0]   pc_r;
  logic [15:0]   idx_r;
  logic [7:0]    dt_r;
  logic [7:0]    st_r;
  logic [7:0]    res_r;
  logic [AW-1:0] maddr_r;
  logic [4:0]    cnt_r;
  logic          pend_r;

  logic          out_valid_r;
  logic [11:0]   out_pc_r;
  logic [15:0]   out_idx_r;
  logic [7:0]    out_dt_r;
  logic [7:0]    out_st_r;
  logic [7:0]    out_vx_r;
  logic [7:0]    out_vf_r;

  c8x_pkg::op_t  op;
  logic [7:0]    vx;
  logic [7:0]    vy;
  logic [7:0]    kk;
  logic [8:0]    sum;
  logic [11:0]   pc_nxt;
  logic [15:0]   idx_nxt;
  logic [7:0]    dt_nxt;
  logic [7:0]    st_nxt;
  logic [7:0]    exec_res;
  logic          exec_wx;
  logic          exec_fw;
  logic          exec_flag;
  logic          is_block;

  logic          in_ready;
  logic [3:0]    ra;
  logic [3:0]    rb;
  logic [3:0]    cnt_prev;
  c8x_pkg::vreg_wr_t vreg_wr;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;
  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] mod_result;
  logic          issue;
  logic          out_free;
  logic [AW-1:0] maddr_inc;
  logic          accept;

  c8x_vregs u_vregs (
    .clk       (clk),
    .wr        (vreg_wr),
    .rd_a_addr (ra),
    .rd_b_addr (rb),
    .rd_a_data (vx),
    .rd_b_data (vy)
  );

  c8x_mem #(.MEM_DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (maddr_r),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  c8x_addr_mod #(.MEM_DEPTH(MEM_DEPTH)) u_addr_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .value  (idx_r),
    .done   (mod_done),
    .result (mod_result)
  );

  assign op        = c8x_pkg::op_t'(mode_r);
  assign kk        = c8x_pkg::field_kk(word_r);
  assign sum       = {1'b0, vx} + {1'b0, vy};
  assign issue     = (cnt_r <= {1'b0, x_r});
  assign cnt_prev  = 4'(cnt_r - 5'd1);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign maddr_inc = (maddr_r == LAST_ADDR) ? '0 : AW'(maddr_r + 1'b1);
  assign is_block  = (op == c8x_pkg::OP_STORE) || (op == c8x_pkg::OP_LOAD);
  assign accept    = in_ch.valid && in_ready;

  // Execute: vx / vy come from the register file reads issued at transfer
  always_comb begin
    pc_nxt    = pc_r;
    idx_nxt   = idx_r;
    dt_nxt    = dt_r;
    st_nxt    = st_r;
    exec_res  = vx;
    exec_wx   = 1'b0;
    exec_fw   = 1'b0;
    exec_flag = 1'b0;
    case (op)
      c8x_pkg::OP_JP:      pc_nxt = c8x_pkg::field_nnn(word_r);
      c8x_pkg::OP_SE_KK:   if (vx == kk) pc_nxt = pc_r + 12'd2;
      c8x_pkg::OP_SE_XY:   if (vx == vy) pc_nxt = pc_r + 12'd2;
      c8x_pkg::OP_SNE_KK:  if (vx != kk) pc_nxt = pc_r + 12'd2;
      c8x_pkg::OP_SNE_XY:  if (vx != vy) pc_nxt = pc_r + 12'd2;
      c8x_pkg::OP_LD_KK: begin
        exec_res = kk;
        exec_wx  = 1'b1;
      end
      c8x_pkg::OP_LD_XY: begin
        exec_res = vy;
        exec_wx  = 1'b1;
      end
      c8x_pkg::OP_LD_I:    idx_nxt = {4'b0, c8x_pkg::field_nnn(word_r)};
      c8x_pkg::OP_LD_X_DT: begin
        exec_res = dt_r;
        exec_wx  = 1'b1;
      end
      c8x_pkg::OP_LD_DT_X: dt_nxt = vx;
      c8x_pkg::OP_LD_ST_X: st_nxt = vx;
      c8x_pkg::OP_ADD_KK: begin
        exec_res = vx + kk;
        exec_wx  = 1'b1;
      end
      c8x_pkg::OP_ADD_XY: begin
        exec_res  = sum[7:0];
        exec_wx   = 1'b1;
        exec_fw   = 1'b1;
        exec_flag = sum[8];
      end
      c8x_pkg::OP_ADD_I:   idx_nxt = idx_r + {8'b0, vx};
      c8x_pkg::OP_SUB: begin
        exec_res  = vx - vy;
        exec_wx   = 1'b1;
        exec_fw   = 1'b1;
        exec_flag = (vx > vy);
      end
      c8x_pkg::OP_SUBN: begin
        exec_res  = vy - vx;
        exec_wx   = 1'b1;
        exec_fw   = 1'b1;
        exec_flag = (vy > vx);
      end
      c8x_pkg::OP_OR: begin
        exec_res = vx | vy;
        exec_wx  = 1'b1;
      end
      c8x_pkg::OP_AND: begin
        exec_res = vx & vy;
        exec_wx  = 1'b1;
      end
      c8x_pkg::OP_XOR: begin
        exec_res = vx ^ vy;
        exec_wx  = 1'b1;
      end
      c8x_pkg::OP_SHR: begin
        exec_res  = vx >> 1;
        exec_wx   = 1'b1;
        exec_fw   = 1'b1;
        exec_flag = vx[0];
      end
      c8x_pkg::OP_SHL: begin
        exec_res  = (vx << 1) & c8x_pkg::BYTE_MAX;
        exec_wx   = 1'b1;
        exec_fw   = 1'b1;
        exec_flag = ((vx & c8x_pkg::MSB_MASK) != 8'd0);
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      c8x_pkg::ST_CLEAR: if (maddr_r == LAST_ADDR) state_nxt = c8x_pkg::ST_IDLE;
      c8x_pkg::ST_IDLE:  if (in_ch.valid) state_nxt = c8x_pkg::ST_EXEC;
      c8x_pkg::ST_EXEC: begin
        if (is_block) begin
          state_nxt = c8x_pkg::ST_MOD;
        end else if (exec_wx) begin
          state_nxt = c8x_pkg::ST_WBX;
        end else begin
          state_nxt = c8x_pkg::ST_OUTRD;
        end
      end
      c8x_pkg::ST_WBX:   state_nxt = c8x_pkg::ST_OUTRD;
      c8x_pkg::ST_MOD: begin
        if (mod_done) begin
          state_nxt = (op == c8x_pkg::OP_STORE) ? c8x_pkg::ST_STORE : c8x_pkg::ST_LOAD;
        end
      end
      c8x_pkg::ST_STORE: if (!issue) state_nxt = c8x_pkg::ST_OUTRD;
      c8x_pkg::ST_LOAD:  if (!issue) state_nxt = c8x_pkg::ST_OUTRD;
      c8x_pkg::ST_OUTRD: state_nxt = c8x_pkg::ST_OUT;
      c8x_pkg::ST_OUT:   if (out_free) state_nxt = c8x_pkg::ST_IDLE;
      default:           state_nxt = c8x_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: input ready, register file ports, memory port, reduction start
  always_comb begin
    in_ready     = 1'b0;
    ra           = x_r;
    rb           = c8x_pkg::VF_ADDR;
    vreg_wr.en   = 1'b0;
    vreg_wr.addr = x_r;
    vreg_wr.data = res_r;
    mem_we       = 1'b0;
    mem_wdata    = vx;
    mod_start    = 1'b0;
    case (state_r)
      c8x_pkg::ST_CLEAR: begin
        // zero the memory and, on the first sixteen addresses, the V registers
        vreg_wr.en   = (maddr_r >> 4) == '0;
        vreg_wr.addr = maddr_r[3:0];
        vreg_wr.data = 8'd0;
        mem_we       = 1'b1;
        mem_wdata    = 8'd0;
      end
      c8x_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ra       = c8x_pkg::field_x(in_ch.instruction_word);
        rb       = c8x_pkg::field_y(in_ch.instruction_word);
      end
      c8x_pkg::ST_EXEC: begin
        // flag goes first so that a result aimed at VF lands last
        vreg_wr.en   = exec_fw;
        vreg_wr.addr = c8x_pkg::VF_ADDR;
        vreg_wr.data = {7'b0, exec_flag};
        mod_start    = is_block;
      end
      c8x_pkg::ST_WBX: begin
        vreg_wr.en = 1'b1;
      end
      c8x_pkg::ST_STORE: begin
        ra     = cnt_r[3:0];
        mem_we = pend_r;
      end
      c8x_pkg::ST_LOAD: begin
        vreg_wr.en   = pend_r;
        vreg_wr.addr = cnt_prev;
        vreg_wr.data = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= c8x_pkg::ST_CLEAR;
      maddr_r     <= '0;
      pc_r        <= '0;
      idx_r       <= '0;
      dt_r        <= '0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == c8x_pkg::ST_EXEC) begin
        pc_r  <= pc_nxt;
        idx_r <= idx_nxt;
        dt_r  <= dt_nxt;
        st_r  <= st_nxt;
      end
      case (state_r)
        c8x_pkg::ST_CLEAR: maddr_r <= AW'(maddr_r + 1'b1);
        c8x_pkg::ST_MOD: begin
          maddr_r <= mod_result;
          cnt_r   <= '0;
          pend_r  <= 1'b0;
        end
        c8x_pkg::ST_STORE: begin
          if (pend_r) maddr_r <= maddr_inc;
          if (issue) cnt_r <= cnt_r + 5'd1;
          pend_r <= issue;
        end
        c8x_pkg::ST_LOAD: begin
          if (issue) begin
            maddr_r <= maddr_inc;
            cnt_r   <= cnt_r + 5'd1;
          end
          pend_r <= issue;
        end
        default: ;
      endcase
      if ((state_r == c8x_pkg::ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_ch.mode;
      word_r <= in_ch.instruction_word;
      x_r    <= c8x_pkg::field_x(in_ch.instruction_word);
    end
    if (state_r == c8x_pkg::ST_EXEC) begin
      res_r <= exec_res;
    end
    if ((state_r == c8x_pkg::ST_OUT) && out_free) begin
      out_pc_r  <= pc_r;
      out_idx_r <= idx_r;
      out_dt_r  <= dt_r;
      out_st_r  <= st_r;
      out_vx_r  <= vx;
      out_vf_r  <= vy;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.program_counter = out_pc_r;
  assign out_ch.index_value     = out_idx_r;
  assign out_ch.delay_value     = out_dt_r;
  assign out_ch.sound_value     = out_st_r;
  assign out_ch.vx_value        = out_vx_r;
  assign out_ch.flag_value      = out_vf_r;

endmodule
`default_nettype wire

// ----- design/c8x_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "chip8_instruction_execute_defines.svh"

module c8x_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // reset starts the memory sweep: no transfer in, nothing out
  `C8X_CHECK_RST(a_reset_blocks_input, !rst_n |=> !in_ready, "input ready right after reset")
  `C8X_CHECK_RST(a_reset_drops_output, !rst_n |=> !out_valid, "result valid right after reset")
  // one instruction at a time: busy right after a transfer
  `C8X_CHECK(a_busy_after_transfer, (in_valid && in_ready) |=> !in_ready, "ready held after transfer")
  `C8X_CHECK(a_result_held, (out_valid && !out_ready) |=> out_valid, "stalled result dropped")

endmodule

bind chip8_instruction_execute c8x_checker u_c8x_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
`default_nettype wire
